// ----- sv/bfs_pkg.sv -----
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared constants and types for the byte queue with membership search.
// ----------------------------------------------------------------------------
package bfs_pkg;

  // Queue geometry.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Payload field widths.
  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int OUT_CNT_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS  = 3'd4;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              shift;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] key;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

  // Status reported by one cell.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              match;
    logic              is_back;
  } cell_stat_t;

endpackage

// ----- sv/bfs_in_if.sv -----
// ----------------------------------------------------------------------------
// bfs_in_if
// Operation channel: valid/ready handshake carrying one queue operation.
// ----------------------------------------------------------------------------
interface bfs_in_if import bfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- sv/bfs_out_if.sv -----
// ----------------------------------------------------------------------------
// bfs_out_if
// Result channel: valid/ready handshake carrying the outcome and a queue snapshot.
// ----------------------------------------------------------------------------
interface bfs_out_if import bfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic                 found;
  logic [BYTE_W-1:0]    front_value;
  logic [BYTE_W-1:0]    back_value;
  logic [OUT_CNT_W-1:0] entry_count;
  logic                 is_empty;

  modport source (output valid, output accepted, output found, output front_value,
                  output back_value, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input accepted, input found, input front_value,
                  input back_value, input entry_count, input is_empty,
                  output ready);
endinterface

// ----- sv/bfs_cell.sv -----
// ----------------------------------------------------------------------------
// bfs_cell
// One queue slot: holds a byte, shifts toward the front on dequeue, and
// compares its byte against the search key.
// ----------------------------------------------------------------------------
module bfs_cell import bfs_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] nbr_data,
  output cell_stat_t        stat
);

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;
  logic [CNT_W-1:0]  pos;
  logic              live;

  // Position of this slot widened to the count width.
  assign pos  = CNT_W'(idx);
  assign live = (pos < ctl.count);

  // Take the neighbor's byte on a dequeue, or a new byte when addressed.
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = nbr_data;
    end else if (ctl.wr_en && (ctl.wr_idx == idx)) begin
      data_nxt = ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Report the byte, a match against the key, and whether this is the newest entry.
  assign stat.data    = data_r;
  assign stat.match   = live && (data_r == ctl.key);
  assign stat.is_back = ((pos + CNT_W'(1)) == ctl.count);

endmodule

// ----- sv/byte_fifo_with_search_unit.sv -----
// Two register stages: an accepted operation passes the pending stage, then the output register.
// Throughput: one operation per cycle while results are taken, set by the
// single pending stage in front of the output register.
// Reset clears the entry count, the pending stage and the output valid flag;
// slot contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
// byte_fifo_with_search_unit
// Byte queue built as a shifting chain of slots, front at slot zero, with a
// parallel membership search across all live slots.
// ----------------------------------------------------------------------------
module byte_fifo_with_search_unit import bfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bfs_in_if.sink    in_chan,
  bfs_out_if.source out_chan
);

  cell_ctl_t         ctl;
  cell_stat_t        stat [DEPTH];
  logic [BYTE_W-1:0] nbr  [DEPTH];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              pend_r;
  logic              pend_acc_r;
  logic              pend_found_r;
  logic              acc_nxt;
  logic              found_nxt;
  logic              in_fire;
  logic              out_load;
  logic              any_match;
  logic              empty;
  logic              full;
  logic [BYTE_W-1:0] back_data;

  logic                 out_valid_r;
  logic                 out_acc_r;
  logic                 out_found_r;
  logic [BYTE_W-1:0]    out_front_r;
  logic [BYTE_W-1:0]    out_back_r;
  logic [OUT_CNT_W-1:0] out_count_r;
  logic                 out_empty_r;

  // Handshake: the pending stage drains into the output register.
  assign out_load      = pend_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !pend_r || out_load;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));

  // Decode the operation into chain control and the item outcome.
  always_comb begin
    ctl.shift   = 1'b0;
    ctl.wr_en   = 1'b0;
    ctl.wr_idx  = count_r[IDX_W-1:0];
    ctl.wr_data = in_chan.value;
    ctl.key     = in_chan.value;
    ctl.count   = count_r;
    count_nxt   = count_r;
    acc_nxt     = 1'b0;
    found_nxt   = 1'b0;
    unique case (in_chan.operation)
      OP_ENQUEUE: begin
        if (!full) begin
          ctl.wr_en = in_fire;
          acc_nxt   = 1'b1;
          if (in_fire) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      OP_DEQUEUE: begin
        if (!empty) begin
          ctl.shift = in_fire;
          acc_nxt   = 1'b1;
          if (in_fire) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      OP_SEARCH: begin
        acc_nxt   = !empty;
        found_nxt = any_match;
      end
      OP_REPLACE: begin
        if (!empty) begin
          ctl.wr_en  = in_fire;
          ctl.wr_idx = IDX_W'(count_r - CNT_W'(1));
          acc_nxt    = 1'b1;
        end
      end
      OP_STATUS: begin
        acc_nxt = 1'b1;
      end
      default: begin
        acc_nxt = 1'b0;
      end
    endcase
  end

  // Chain of slots; each takes its upper neighbor's byte on a dequeue.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = stat[i+1].data;
    end
    bfs_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(i)),
      .ctl      (ctl),
      .nbr_data (nbr[i]),
      .stat     (stat[i])
    );
  end

  // Gather the match flags and the newest entry's byte.
  always_comb begin
    any_match = 1'b0;
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_match = any_match | stat[i].match;
      back_data = back_data | (stat[i].is_back ? stat[i].data : '0);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: outcome of the accepted item, then the snapshot.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_acc_r   <= acc_nxt;
      pend_found_r <= found_nxt;
    end
    if (out_load) begin
      out_acc_r   <= pend_acc_r;
      out_found_r <= pend_found_r;
      out_front_r <= empty ? '0 : stat[0].data;
      out_back_r  <= back_data;
      out_count_r <= OUT_CNT_W'(count_r);
      out_empty_r <= empty;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.accepted    = out_acc_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.front_value = out_front_r;
  assign out_chan.back_value  = out_back_r;
  assign out_chan.entry_count = out_count_r;
  assign out_chan.is_empty    = out_empty_r;

  // The entry count never passes the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // An accepted enqueue on a queue with room adds exactly one entry.
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.operation == OP_ENQUEUE) && !full)
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not add one entry");

  // An accepted dequeue on a non-empty queue removes exactly one entry.
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.operation == OP_DEQUEUE) && !empty)
      |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue did not remove one entry");

  // Every accepted item leaves a pending result behind it.
  a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_r)
    else $error("accepted item lost before the output stage");

endmodule
